[sv/bgt_pkg.sv]
package bgt_pkg;

  // Geometry of the row store
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int BANKS     = 4;

  // Register and field widths
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int THR_W      = 8;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Width of column arithmetic: room for a column, a width and one carry
  localparam int CNT_W = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;

  // Register reset values and limits
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 13'd480;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 8'd140;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH       = 11'd5;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT      = 13'd5;
  localparam logic [HEIGHT_W-1:0] ROW_MAX         = 13'h1FFF;

  // Reciprocals for the constant divisions (16 fractional bits)
  localparam logic [12:0] RECIP_10 = 13'd6554;
  localparam logic [14:0] RECIP_3  = 15'd21846;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // Item handed from the front end to the result pipeline
  typedef struct packed {
    logic       result;
    logic       vertical;
    logic       frame_end;
    logic [1:0] slot;
    pixel_t     hres;
  } item_t;

  // Row store write request
  typedef struct packed {
    logic             en;
    logic [1:0]       slot;
    logic [COL_W-1:0] addr;
    pixel_t           data;
  } row_write_t;

  // Divide a tap sum (at most 2550) by 10
  function automatic logic [CHAN_W-1:0] div10(input logic [11:0] s);
    logic [24:0] p;
    p = {13'd0, s} * {12'd0, RECIP_10};
    return p[23:16];
  endfunction

  // Divide a channel sum (at most 765) by 3
  function automatic logic [CHAN_W-1:0] div3(input logic [9:0] s);
    logic [24:0] p;
    p = {15'd0, s} * {10'd0, RECIP_3};
    return p[23:16];
  endfunction

  // 1-2-4-2-1 over five pixels, divided by 10, per channel
  function automatic pixel_t tap5(input pixel_t a, input pixel_t b, input pixel_t c,
                                  input pixel_t d, input pixel_t e);
    pixel_t      res;
    logic [11:0] s;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      s = {4'd0, a[CHAN_W*k +: CHAN_W]} + {3'd0, b[CHAN_W*k +: CHAN_W], 1'b0}
        + {2'd0, c[CHAN_W*k +: CHAN_W], 2'b0} + {3'd0, d[CHAN_W*k +: CHAN_W], 1'b0}
        + {4'd0, e[CHAN_W*k +: CHAN_W]};
      res[CHAN_W*k +: CHAN_W] = div10(s);
    end
    return res;
  endfunction

  // Truncating average of the three channels
  function automatic logic [CHAN_W-1:0] grey(input pixel_t p);
    logic [9:0] s;
    s = {2'd0, p[7:0]} + {2'd0, p[15:8]} + {2'd0, p[23:16]};
    return div3(s);
  endfunction

endpackage

[sv/bgt_pix_if.sv]
interface bgt_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       frame_start;
  logic       pad;

  modport source (output valid, blue, green, red, frame_start, pad, input ready);
  modport sink   (input valid, blue, green, red, frame_start, pad, output ready);
endinterface

[sv/bgt_res_if.sv]
interface bgt_res_if;
  logic valid;
  logic ready;
  logic foreground;
  logic frame_end;

  modport source (output valid, foreground, frame_end, input ready);
  modport sink   (input valid, foreground, frame_end, output ready);
endinterface

[sv/bgt_ram.sv]
module bgt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read sees the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/bgt_front.sv]
module bgt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     blue,
  input  logic [7:0]                     green,
  input  logic [7:0]                     red,
  input  logic                           frame_start,
  input  logic                           pad,
  input  logic [bgt_pkg::WIDTH_W-1:0]    image_width,
  input  logic [bgt_pkg::HEIGHT_W-1:0]   image_height,
  output bgt_pkg::item_t                 item,
  output bgt_pkg::row_write_t            row_write,
  output logic [bgt_pkg::COL_W-1:0]      read_addr
);

  localparam int CNT_W = bgt_pkg::CNT_W;
  localparam int COL_W = bgt_pkg::COL_W;
  localparam int HEIGHT_W = bgt_pkg::HEIGHT_W;

  logic [bgt_pkg::WIDTH_W-1:0] w;
  logic [HEIGHT_W-1:0]         h;
  logic [CNT_W-1:0]            w_ext;

  logic [COL_W-1:0]    column_count, column_count_next;
  logic [HEIGHT_W-1:0] row_count, row_count_next;
  bgt_pkg::pixel_t     window [4];

  logic [COL_W-1:0]    cc0, cc1;
  logic [HEIGHT_W-1:0] rc0, rc1, qrow, prow;
  logic [CNT_W-1:0]    qcol_ext, cc2;
  logic                qvalid, edge_col;
  bgt_pkg::pixel_t     pix, hres;

  // Clamp the frame size to its legal range
  always_comb begin
    w = image_width;
    if (w < bgt_pkg::MIN_WIDTH) begin
      w = bgt_pkg::MIN_WIDTH;
    end else if (int'(image_width) > bgt_pkg::MAX_WIDTH) begin
      w = bgt_pkg::WIDTH_W'(bgt_pkg::MAX_WIDTH);
    end
    h = (image_height < bgt_pkg::MIN_HEIGHT) ? bgt_pkg::MIN_HEIGHT : image_height;
    w_ext = CNT_W'(w);
  end

  // Position of this item, the horizontal target two items back and its result
  always_comb begin
    cc0 = frame_start ? '0 : column_count;
    rc0 = frame_start ? '0 : row_count;
    cc1 = cc0;
    rc1 = rc0;
    if (CNT_W'(cc0) >= w_ext) begin
      cc1 = '0;
      rc1 = (rc0 == bgt_pkg::ROW_MAX) ? rc0 : rc0 + 1'b1;
    end

    pix = pad ? '0 : {red, green, blue};

    qvalid   = 1'b1;
    qcol_ext = '0;
    qrow     = '0;
    if (CNT_W'(cc1) >= CNT_W'(2)) begin
      qcol_ext = CNT_W'(cc1) - CNT_W'(2);
      qrow     = rc1;
    end else if (rc1 != '0) begin
      qcol_ext = CNT_W'(cc1) + w_ext - CNT_W'(2);
      qrow     = rc1 - 1'b1;
    end else begin
      qvalid = 1'b0;
    end

    edge_col = (qcol_ext < CNT_W'(2)) || (qcol_ext >= w_ext - CNT_W'(2));
    hres = edge_col ? window[1]
                    : bgt_pkg::tap5(window[3], window[2], window[1], window[0], pix);

    prow = qrow - HEIGHT_W'(2);
    item.result    = qvalid && (qrow >= HEIGHT_W'(2)) && (prow < h);
    item.vertical  = (prow >= HEIGHT_W'(2))
                  && ({1'b0, prow} + (HEIGHT_W+1)'(3) <= {1'b0, h});
    item.frame_end = (prow == h - 1'b1) && (qcol_ext == w_ext - CNT_W'(1));
    item.slot      = qrow[1:0];
    item.hres      = hres;

    row_write.en   = accept && qvalid;
    row_write.slot = qrow[1:0];
    row_write.addr = qcol_ext[COL_W-1:0];
    row_write.data = hres;
    read_addr      = qcol_ext[COL_W-1:0];

    // Advance to the next position
    cc2 = CNT_W'(cc1) + CNT_W'(1);
    column_count_next = cc2[COL_W-1:0];
    row_count_next    = rc1;
    if (cc2 >= w_ext) begin
      column_count_next = '0;
      row_count_next    = (rc1 == bgt_pkg::ROW_MAX) ? rc1 : rc1 + 1'b1;
    end
  end

  // Hold position and the last four items; update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 4; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      window[3]    <= window[2];
      window[2]    <= window[1];
      window[1]    <= window[0];
      window[0]    <= pix;
    end
  end

endmodule

[sv/bgt_back.sv]
module bgt_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  bgt_pkg::item_t             item,
  input  bgt_pkg::pixel_t            bank_data [bgt_pkg::BANKS],
  input  logic [bgt_pkg::THR_W-1:0]  grey_threshold,
  input  logic                       out_ready,
  output logic                       advance,
  output logic                       out_valid,
  output logic                       foreground,
  output logic                       frame_end
);

  bgt_pkg::item_t  s1;
  logic            s1_valid;
  bgt_pkg::pixel_t s2_blur;
  logic            s2_frame_end;
  logic            s2_valid;
  logic            out_en, s2_en;
  bgt_pkg::pixel_t blur;

  // Each stage moves when the one after it is empty or moving
  assign out_en  = !out_valid || out_ready;
  assign s2_en   = !s2_valid || out_en;
  assign advance = !s1_valid || s2_en;

  // Vertical pass over the four stored rows and the fresh horizontal result
  always_comb begin
    if (s1.vertical) begin
      blur = bgt_pkg::tap5(bank_data[s1.slot], bank_data[2'(s1.slot + 2'd1)],
                           bank_data[2'(s1.slot + 2'd2)], bank_data[2'(s1.slot + 2'd3)],
                           s1.hres);
    end else begin
      blur = bank_data[2'(s1.slot + 2'd2)];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= accept && item.result;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= item;
    end
    if (s2_en) begin
      s2_blur      <= blur;
      s2_frame_end <= s1.frame_end;
    end
    if (out_en) begin
      foreground <= bgt_pkg::grey(s2_blur) > grey_threshold;
      frame_end  <= s2_frame_end;
    end
  end

endmodule

[sv/blur_grey_threshold.sv]
// Channel    Role    Fields
// pixels     sink    blue, green, red, frame_start, pad
// results    source  foreground, frame_end
// cfg_*      write   cfg_index selects image_width, image_height, grey_threshold
//
// One item is accepted per cycle while the result path is not stalled; the
// result it completes reaches the result port through three registers: the
// row store read, the vertical pass and the grey divide.
// Each result belongs to the item 2*width+2 positions earlier in the frame.
// Reset acts as a frame start; the row store is not cleared.
// A stalled result holds while the empty stages behind it still take items.
module blur_grey_threshold (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bgt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgt_pkg::CFG_DATA_W-1:0]  cfg_data,
  bgt_pix_if.sink                         pixels,
  bgt_res_if.source                       results
);

  logic [bgt_pkg::WIDTH_W-1:0]  image_width;
  logic [bgt_pkg::HEIGHT_W-1:0] image_height;
  logic [bgt_pkg::THR_W-1:0]    grey_threshold;

  logic                         accept;
  logic                         advance;
  bgt_pkg::item_t               item;
  bgt_pkg::row_write_t          row_write;
  logic [bgt_pkg::COL_W-1:0]    read_addr;
  bgt_pkg::pixel_t              bank_data [bgt_pkg::BANKS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= bgt_pkg::WIDTH_RESET;
      image_height   <= bgt_pkg::HEIGHT_RESET;
      grey_threshold <= bgt_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (bgt_pkg::cfg_reg_t'(cfg_index))
        bgt_pkg::REG_WIDTH:     image_width    <= cfg_data[bgt_pkg::WIDTH_W-1:0];
        bgt_pkg::REG_HEIGHT:    image_height   <= cfg_data[bgt_pkg::HEIGHT_W-1:0];
        bgt_pkg::REG_THRESHOLD: grey_threshold <= cfg_data[bgt_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pixels.ready = advance;
  assign accept       = pixels.valid && advance;

  bgt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .blue         (pixels.blue),
    .green        (pixels.green),
    .red          (pixels.red),
    .frame_start  (pixels.frame_start),
    .pad          (pixels.pad),
    .image_width  (image_width),
    .image_height (image_height),
    .item         (item),
    .row_write    (row_write),
    .read_addr    (read_addr)
  );

  // Row store: one bank per row modulo four, all read at the same column
  for (genvar b = 0; b < bgt_pkg::BANKS; b++) begin : g_bank
    bgt_ram #(
      .WIDTH (bgt_pkg::PIX_W),
      .DEPTH (bgt_pkg::MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (row_write.en && (row_write.slot == 2'(b))),
      .waddr (row_write.addr),
      .wdata (row_write.data),
      .re    (advance),
      .raddr (read_addr),
      .rdata (bank_data[b])
    );
  end

  bgt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .bank_data      (bank_data),
    .grey_threshold (grey_threshold),
    .out_ready      (results.ready),
    .advance        (advance),
    .out_valid      (results.valid),
    .foreground     (results.foreground),
    .frame_end      (results.frame_end)
  );

endmodule
